[sv/efs_pkg.sv]
// Package for the Ethernet frame statistics block: field widths, codes,
// transaction payload structs and sequencer state types.
// No dependencies; the top level imports it.
`default_nettype none

package efs_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int unsigned DEF_TABLE_DEPTH   = 16;
  localparam int unsigned DEF_COUNTER_WIDTH = 32;

  // Fixed field widths
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned TYPE_W  = 16;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned STAT_W  = 32;
  localparam int unsigned COUNT_W = 5;

  // Group (multicast) bit: least significant bit of the first address byte
  localparam int unsigned GROUP_BIT = 40;

  // Ethertypes with their own byte counters
  localparam logic [TYPE_W-1:0] TYPE_IPV4 = 16'h0800;
  localparam logic [TYPE_W-1:0] TYPE_IPV6 = 16'h86dd;

  // Action codes of an input transaction
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef struct packed {
    logic              action;
    logic [MAC_W-1:0]  dest_mac;
    logic [TYPE_W-1:0] ether_type;
    logic [LEN_W-1:0]  frame_bytes;
    logic [IDX_W-1:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic               entry_valid;
    logic [TYPE_W-1:0]  entry_type;
    logic [STAT_W-1:0]  entry_frames;
    logic [STAT_W-1:0]  entry_bytes;
    logic [STAT_W-1:0]  total_frames;
    logic [STAT_W-1:0]  frames_for_me;
    logic [STAT_W-1:0]  mcast_frames;
    logic [STAT_W-1:0]  recorded_bytes;
    logic [STAT_W-1:0]  ipv4_bytes;
    logic [STAT_W-1:0]  ipv6_bytes;
    logic [COUNT_W-1:0] type_count;
    logic               table_overflow;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_GLOB,
    S_SCAN,
    S_UPD_F,
    S_UPD_B,
    S_WRITE,
    S_RD_REQ,
    S_RD_WAIT,
    S_DONE
  } efs_state_t;

  // Global counter update steps, one shared-adder pass each
  typedef enum logic [1:0] {
    G_FRAMES,
    G_BYTES,
    G_DEST,
    G_TYPE
  } glob_step_t;

endpackage

`default_nettype wire

[sv/efs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the ethertype table entries.
`default_nettype none

module efs_ram #(
  parameter int unsigned WIDTH  = 80,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/efs_sat_add.sv]
// Saturating unsigned adder shared by every counter update of the block.
// No dependencies; instantiated once in the top level.
`default_nettype none

module efs_sat_add #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  output logic      [WIDTH-1:0] sum
);

  logic [WIDTH:0] raw;

  // Add with carry out, clamp to all ones on carry
  always_comb begin
    raw = {1'b0, a} + {1'b0, b};
    sum = raw[WIDTH] ? {WIDTH{1'b1}} : raw[WIDTH-1:0];
  end

endmodule

`default_nettype wire

[sv/ethernet_frame_statistics.sv]
// Top level of the Ethernet frame statistics block: sequencer, global counters,
// ethertype table scan. Depends on efs_pkg, efs_ram and efs_sat_add.
//
//   channel | ports                        | payload          | direction
//   --------+------------------------------+------------------+----------
//   input   | in_valid, in_ready, in_data  | efs_pkg::in_item_t  | in
//   result  | out_valid, out_ready, out_data | efs_pkg::out_item_t | out
//   config  | cfg_wr_en, cfg_wr_data       | own MAC, 48 bits | in
//
// A record transaction makes four adder passes over the global counters, scans the table
// one entry per cycle through the RAM read port, then makes two adder passes and a
// write-back; a new ethertype with the table full skips these and sets the overflow flag.
// A read fetches the indexed slot or reports it empty. A new transaction is accepted
// only in the idle state. Reset is synchronous, active low, and clears
// counters, fill count and flags; a held result stalls the next one in the done state.
`default_nettype none

module ethernet_frame_statistics #(
  parameter int unsigned TABLE_DEPTH   = efs_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned COUNTER_WIDTH = efs_pkg::DEF_COUNTER_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire efs_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output efs_pkg::out_item_t               out_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic [efs_pkg::MAC_W-1:0]   cfg_wr_data
);

  import efs_pkg::*;

  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (NW > IDX_W) ? NW : IDX_W;
  localparam int unsigned EW = TYPE_W + 2 * CW;

  // Sequencer and transaction registers
  efs_state_t      state_r, state_nxt;
  glob_step_t      gstep_r, gstep_nxt;
  in_item_t        item_r, item_nxt;
  logic [MAC_W-1:0] own_mac_r;

  // Global counters
  logic [CW-1:0] frame_cnt_r, frame_cnt_nxt;
  logic [CW-1:0] mine_cnt_r, mine_cnt_nxt;
  logic [CW-1:0] group_cnt_r, group_cnt_nxt;
  logic [CW-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [CW-1:0] v4_cnt_r, v4_cnt_nxt;
  logic [CW-1:0] v6_cnt_r, v6_cnt_nxt;
  logic [NW-1:0] used_r, used_nxt;
  logic          ovf_r, ovf_nxt;

  // Scan and working entry
  logic [NW-1:0]     scan_idx_r, scan_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]     tgt_idx_r, tgt_idx_nxt;
  logic              is_new_r, is_new_nxt;
  logic              ent_vld_r, ent_vld_nxt;
  logic [TYPE_W-1:0] ent_type_r, ent_type_nxt;
  logic [CW-1:0]     ent_frames_r, ent_frames_nxt;
  logic [CW-1:0]     ent_bytes_r, ent_bytes_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  // Shared adder and table RAM
  logic [CW-1:0]     sa_a, sa_b, sa_sum;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;
  logic [TYPE_W-1:0] rd_type;
  logic [CW-1:0]     rd_frames, rd_bytes;

  // Decode
  logic          is_mine, is_group, is_v4, is_v6;
  logic          scan_more, scan_hit, scan_miss, has_room, rd_ok, done_go;
  logic [IW-1:0] idx_ext;
  logic [CW-1:0] len_ext;

  efs_sat_add #(
    .WIDTH (CW)
  ) u_sat_add (
    .a   (sa_a),
    .b   (sa_b),
    .sum (sa_sum)
  );

  efs_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_type_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tgt_idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Unpack the table entry and decode the held transaction
  assign ram_wdata = {ent_type_r, ent_frames_r, ent_bytes_r};
  assign rd_type   = ram_rdata[EW-1 -: TYPE_W];
  assign rd_frames = ram_rdata[2*CW-1 -: CW];
  assign rd_bytes  = ram_rdata[CW-1:0];

  assign is_mine   = (item_r.dest_mac == own_mac_r);
  assign is_group  = item_r.dest_mac[GROUP_BIT];
  assign is_v4     = (item_r.ether_type == TYPE_IPV4);
  assign is_v6     = (item_r.ether_type == TYPE_IPV6);
  assign len_ext   = CW'(item_r.frame_bytes);

  assign scan_more = (scan_idx_r < used_r);
  assign scan_hit  = rd_vld_r && (rd_type == item_r.ether_type);
  assign scan_miss = !rd_vld_r && !scan_more;
  assign has_room  = (used_r < NW'(TABLE_DEPTH));

  assign idx_ext   = IW'(item_r.entry_index);
  assign rd_ok     = (idx_ext < IW'(used_r)) && (idx_ext < IW'(TABLE_DEPTH));
  assign done_go   = !out_valid_r || out_ready;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.action == ACT_READ) ? S_RD_REQ : S_GLOB;
        end
      end
      S_GLOB: begin
        if (gstep_r == G_TYPE) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_nxt = S_UPD_F;
        end else if (scan_miss) begin
          state_nxt = has_room ? S_UPD_F : S_DONE;
        end
      end
      S_UPD_F:   state_nxt = S_UPD_B;
      S_UPD_B:   state_nxt = S_WRITE;
      S_WRITE:   state_nxt = S_DONE;
      S_RD_REQ:  state_nxt = rd_ok ? S_RD_WAIT : S_DONE;
      S_RD_WAIT: state_nxt = S_DONE;
      S_DONE: begin
        if (done_go) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    gstep_nxt      = gstep_r;
    item_nxt       = item_r;
    frame_cnt_nxt  = frame_cnt_r;
    mine_cnt_nxt   = mine_cnt_r;
    group_cnt_nxt  = group_cnt_r;
    byte_cnt_nxt   = byte_cnt_r;
    v4_cnt_nxt     = v4_cnt_r;
    v6_cnt_nxt     = v6_cnt_r;
    used_nxt       = used_r;
    ovf_nxt        = ovf_r;
    scan_idx_nxt   = scan_idx_r;
    rd_vld_nxt     = rd_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    tgt_idx_nxt    = tgt_idx_r;
    is_new_nxt     = is_new_r;
    ent_vld_nxt    = ent_vld_r;
    ent_type_nxt   = ent_type_r;
    ent_frames_nxt = ent_frames_r;
    ent_bytes_nxt  = ent_bytes_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    sa_a           = '0;
    sa_b           = '0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state_r)
      // Capture the transaction
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          gstep_nxt = G_FRAMES;
        end
      end

      // Advance the global counters, one per cycle through the shared adder
      S_GLOB: begin
        case (gstep_r)
          G_FRAMES: begin
            sa_a          = frame_cnt_r;
            sa_b          = CW'(1);
            frame_cnt_nxt = sa_sum;
            gstep_nxt     = G_BYTES;
          end
          G_BYTES: begin
            sa_a         = byte_cnt_r;
            sa_b         = len_ext;
            byte_cnt_nxt = sa_sum;
            gstep_nxt    = G_DEST;
          end
          G_DEST: begin
            sa_b = CW'(1);
            if (is_mine) begin
              sa_a         = mine_cnt_r;
              mine_cnt_nxt = sa_sum;
            end else if (is_group) begin
              sa_a          = group_cnt_r;
              group_cnt_nxt = sa_sum;
            end
            gstep_nxt = G_TYPE;
          end
          G_TYPE: begin
            sa_b = len_ext;
            if (is_v4) begin
              sa_a       = v4_cnt_r;
              v4_cnt_nxt = sa_sum;
            end else if (is_v6) begin
              sa_a       = v6_cnt_r;
              v6_cnt_nxt = sa_sum;
            end
            scan_idx_nxt = '0;
            rd_vld_nxt   = 1'b0;
          end
          default: gstep_nxt = G_FRAMES;
        endcase
      end

      // Scan the table: issue one read per cycle, compare the previous one
      S_SCAN: begin
        if (scan_hit) begin
          ent_vld_nxt    = 1'b1;
          ent_type_nxt   = rd_type;
          ent_frames_nxt = rd_frames;
          ent_bytes_nxt  = rd_bytes;
          tgt_idx_nxt    = cmp_idx_r;
          is_new_nxt     = 1'b0;
        end else if (scan_miss) begin
          ent_type_nxt   = item_r.ether_type;
          ent_frames_nxt = '0;
          ent_bytes_nxt  = '0;
          if (has_room) begin
            ent_vld_nxt = 1'b1;
            tgt_idx_nxt = used_r[AW-1:0];
            is_new_nxt  = 1'b1;
          end else begin
            ent_vld_nxt = 1'b0;
            ovf_nxt     = 1'b1;
          end
        end else if (scan_more) begin
          ram_re       = 1'b1;
          ram_raddr    = scan_idx_r[AW-1:0];
          cmp_idx_nxt  = scan_idx_r[AW-1:0];
          scan_idx_nxt = scan_idx_r + 1'b1;
          rd_vld_nxt   = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
        end
      end

      // Bump the entry counters through the shared adder
      S_UPD_F: begin
        sa_a           = ent_frames_r;
        sa_b           = CW'(1);
        ent_frames_nxt = sa_sum;
      end
      S_UPD_B: begin
        sa_a          = ent_bytes_r;
        sa_b          = len_ext;
        ent_bytes_nxt = sa_sum;
      end

      // Write back the entry, append when new
      S_WRITE: begin
        ram_we = 1'b1;
        if (is_new_r) begin
          used_nxt = used_r + 1'b1;
        end
      end

      // Read transaction: fetch the indexed slot or report it empty
      S_RD_REQ: begin
        if (rd_ok) begin
          ram_re    = 1'b1;
          ram_raddr = idx_ext[AW-1:0];
        end else begin
          ent_vld_nxt    = 1'b0;
          ent_type_nxt   = '0;
          ent_frames_nxt = '0;
          ent_bytes_nxt  = '0;
        end
      end
      S_RD_WAIT: begin
        ent_vld_nxt    = 1'b1;
        ent_type_nxt   = rd_type;
        ent_frames_nxt = rd_frames;
        ent_bytes_nxt  = rd_bytes;
      end

      // Load the result once the output register is free
      S_DONE: begin
        if (done_go) begin
          out_valid_nxt            = 1'b1;
          out_nxt.entry_valid      = ent_vld_r;
          out_nxt.entry_type       = ent_type_r;
          out_nxt.entry_frames     = STAT_W'(ent_frames_r);
          out_nxt.entry_bytes      = STAT_W'(ent_bytes_r);
          out_nxt.total_frames     = STAT_W'(frame_cnt_r);
          out_nxt.frames_for_me    = STAT_W'(mine_cnt_r);
          out_nxt.mcast_frames     = STAT_W'(group_cnt_r);
          out_nxt.recorded_bytes   = STAT_W'(byte_cnt_r);
          out_nxt.ipv4_bytes       = STAT_W'(v4_cnt_r);
          out_nxt.ipv6_bytes       = STAT_W'(v6_cnt_r);
          out_nxt.type_count       = COUNT_W'(used_r);
          out_nxt.table_overflow   = ovf_r;
        end
      end

      default: begin
        rd_vld_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gstep_r     <= G_FRAMES;
      own_mac_r   <= '0;
      frame_cnt_r <= '0;
      mine_cnt_r  <= '0;
      group_cnt_r <= '0;
      byte_cnt_r  <= '0;
      v4_cnt_r    <= '0;
      v6_cnt_r    <= '0;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gstep_r     <= gstep_nxt;
      if (cfg_wr_en) begin
        own_mac_r <= cfg_wr_data;
      end
      frame_cnt_r <= frame_cnt_nxt;
      mine_cnt_r  <= mine_cnt_nxt;
      group_cnt_r <= group_cnt_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      v4_cnt_r    <= v4_cnt_nxt;
      v6_cnt_r    <= v6_cnt_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    tgt_idx_r    <= tgt_idx_nxt;
    is_new_r     <= is_new_nxt;
    ent_vld_r    <= ent_vld_nxt;
    ent_type_r   <= ent_type_nxt;
    ent_frames_r <= ent_frames_nxt;
    ent_bytes_r  <= ent_bytes_nxt;
    out_r        <= out_nxt;
  end

  // Fill count never passes the table depth
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= NW'(TABLE_DEPTH))
    else $error("table fill count exceeds depth");

  // Fill count moves only on a write-back
  a_used_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_WRITE) |=> $stable(used_r))
    else $error("table fill count changed outside write-back");

  // Overflow flag is sticky
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared");

  // An update of an existing entry targets a filled slot
  a_hit_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && !is_new_r) |-> (NW'(tgt_idx_r) < used_r))
    else $error("entry update beyond fill count");

  // A result appears only from the done state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside done state");

endmodule

`default_nettype wire
